// ----- hw/rtl/assert_macros.svh -----
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds on every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- hw/rtl/ffh_pkg.sv -----
// types, constants and slot helpers for the hopscotch fingerprint filter
// no dependencies
`timescale 1ns / 1ps
package ffh_pkg;

  localparam int unsigned MaxBuckets  = 1024;
  localparam int unsigned AddrW       = $clog2(MaxBuckets);
  localparam int unsigned MaxLog2     = AddrW;
  localparam int unsigned MaxProbe    = 16;
  localparam int unsigned SlotW       = 16;
  localparam int unsigned Slots       = 4;
  localparam int unsigned WordW       = SlotW * Slots;
  localparam int unsigned FpW         = 12;
  localparam int unsigned DistW       = 4;

  localparam logic [1:0] OpInsert = 2'd0;
  localparam logic [1:0] OpLookup = 2'd1;
  localparam logic [1:0] OpClear  = 2'd2;
  localparam logic [1:0] OpNone   = 2'd3;

  localparam logic RegBucketLog2 = 1'b0;

  typedef logic [WordW-1:0] word_t;
  typedef logic [SlotW-1:0] slot_t;

  function automatic slot_t get_slot(word_t w, logic [1:0] s);
    return w[s*SlotW +: SlotW];
  endfunction

  function automatic word_t put_slot(word_t w, logic [1:0] s, slot_t v);
    word_t r;
    r = w;
    r[s*SlotW +: SlotW] = v;
    return r;
  endfunction

endpackage

// ----- hw/rtl/fingerprint_filter_hopscotch.sv -----
// hopscotch fingerprint filter: fsm around one 1024 x 64 bucket memory
// depends on ffh_pkg
`timescale 1ns / 1ps
// steps: lookup reads and checks each probed bucket (up to 16); insert scans buckets, then reads
// and moves displacement candidates, then writes the fingerprint; clear sweeps all 1024 buckets
// throughput: one item at a time; a new item is taken only in idle with no result pending
// reset: a clearing pass sweeps all 1024 buckets of the memory; no input is taken meanwhile
module fingerprint_filter_hopscotch (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,   // opcode[1:0], hash_value[65:2], zero pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // success[0], zero pad
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ffh_pkg::*;

  typedef enum logic [8:0] {
    StClr    = 9'b000000001,
    StIdle   = 9'b000000010,
    StScanRd = 9'b000000100,
    StScanEv = 9'b000001000,
    StDispRd = 9'b000010000,
    StDispEv = 9'b000100000,
    StFinWr  = 9'b001000000,
    StLookRd = 9'b010000000,
    StLookEv = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  logic [3:0]        lg_q;
  logic [AddrW-1:0]  clr_q, clr_d;
  logic [AddrW:0]    d_q, d_d;
  logic [AddrW-1:0]  cur_d_q, cur_d_d;
  logic [1:0]        cur_s_q, cur_s_d;
  logic [DistW-1:0]  p_q, p_d;
  logic [AddrW-1:0]  home_q;
  logic [FpW-1:0]    fp_q;
  logic [1:0]        op_q;
  word_t             hole_q, hole_d;
  logic              res_pend_q, res_pend_d, res_q, res_d;
  logic              out_valid_q, out_bit_q;

  word_t             mem [MaxBuckets];
  word_t             rdata_q;
  logic              rd_en, we;
  logic [AddrW-1:0]  raddr, waddr;
  word_t             wdata;

  logic [3:0]        lg_eff;
  logic [AddrW-1:0]  mask;
  logic [AddrW:0]    n_buckets;
  logic [FpW-1:0]    in_fp;
  logic              accept, cfg_we;

  assign lg_eff    = (lg_q > 4'(MaxLog2)) ? 4'(MaxLog2) : lg_q;
  assign n_buckets = (AddrW+1)'(1) << lg_eff;
  assign mask      = AddrW'(n_buckets - (AddrW+1)'(1));
  assign in_fp     = (s_axis_tdata[45:34] == '0) ? FpW'(1) : s_axis_tdata[45:34];

  assign s_axis_tready = (state_q == StIdle) && !res_pend_q;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_bit_q};

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == RegBucketLog2);
  assign prdata = (paddr[2] == RegBucketLog2) ? {28'd0, lg_q} : 32'd0;

  // first empty slot, first movable candidate and lookup match in the read word
  logic        zero_hit, cand_hit, look_hit;
  logic [1:0]  zero_s, cand_s;
  slot_t       cand_v;
  logic [AddrW-1:0] cur_after;

  always_comb begin
    slot_t sv;
    zero_hit = 1'b0;
    zero_s   = 2'd0;
    cand_hit = 1'b0;
    cand_s   = 2'd0;
    look_hit = 1'b0;
    sv       = '0;
    for (int s = Slots - 1; s >= 0; s--) begin
      sv = get_slot(rdata_q, 2'(s));
      if (sv == '0) begin
        zero_hit = 1'b1;
        zero_s   = 2'(s);
      end
      if ({1'b0, sv[DistW-1:0]} + {1'b0, p_q} < 5'(MaxProbe)) begin
        cand_hit = 1'b1;
        cand_s   = 2'(s);
      end
      if (sv == {fp_q, p_q}) look_hit = 1'b1;
    end
    cand_v    = get_slot(rdata_q, cand_s);
    cur_after = cur_d_q - AddrW'(p_q);
  end

  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    d_d        = d_q;
    cur_d_d    = cur_d_q;
    cur_s_d    = cur_s_q;
    p_d        = p_q;
    hole_d     = hole_q;
    res_pend_d = res_pend_q;
    res_d      = res_q;
    rd_en      = 1'b0;
    raddr      = (home_q + AddrW'(p_q)) & mask;
    we         = 1'b0;
    waddr      = clr_q;
    wdata      = '0;
    if (res_pend_q && (!out_valid_q || m_axis_tready)) res_pend_d = 1'b0;
    unique case (state_q)
      StClr: begin
        we    = 1'b1;
        clr_d = clr_q + AddrW'(1);
        if (clr_q == AddrW'(MaxBuckets - 1)) begin
          state_d = StIdle;
          if (op_q == OpClear && res_pend_q) res_pend_d = 1'b1;
        end
      end
      StIdle: begin
        if (accept) begin
          d_d = '0;
          p_d = '0;
          unique case (s_axis_tdata[1:0])
            OpInsert: state_d = StScanRd;
            OpLookup: state_d = StLookRd;
            OpClear: begin
              clr_d   = '0;
              state_d = StClr;
              res_d   = 1'b1;
              res_pend_d = 1'b1;
            end
            OpNone: begin
              res_d      = 1'b0;
              res_pend_d = 1'b1;
            end
            default: ;
          endcase
        end
      end
      StScanRd: begin
        rd_en   = 1'b1;
        raddr   = (home_q + d_q[AddrW-1:0]) & mask;
        state_d = StScanEv;
      end
      StScanEv: begin
        if (zero_hit) begin
          cur_d_d = d_q[AddrW-1:0];
          cur_s_d = zero_s;
          hole_d  = rdata_q;
          if (d_q < (AddrW+1)'(MaxProbe)) begin
            we         = 1'b1;
            waddr      = (home_q + d_q[AddrW-1:0]) & mask;
            wdata      = put_slot(rdata_q, zero_s, {fp_q, d_q[DistW-1:0]});
            res_d      = 1'b1;
            res_pend_d = 1'b1;
            state_d    = StIdle;
          end else begin
            p_d     = DistW'(MaxProbe - 1);
            state_d = StDispRd;
          end
        end else if (d_q + (AddrW+1)'(1) == n_buckets) begin
          res_d      = 1'b0;
          res_pend_d = 1'b1;
          state_d    = StIdle;
        end else begin
          d_d     = d_q + (AddrW+1)'(1);
          state_d = StScanRd;
        end
      end
      StDispRd: begin
        rd_en   = 1'b1;
        raddr   = (home_q + cur_after) & mask;
        state_d = StDispEv;
      end
      StDispEv: begin
        if (cand_hit) begin
          we      = 1'b1;
          waddr   = (home_q + cur_d_q) & mask;
          wdata   = put_slot(hole_q, cur_s_q,
                             {cand_v[SlotW-1:DistW], cand_v[DistW-1:0] + p_q});
          cur_d_d = cur_after;
          cur_s_d = cand_s;
          hole_d  = rdata_q;
          if (cur_after < AddrW'(MaxProbe)) begin
            state_d = StFinWr;
          end else begin
            p_d     = DistW'(MaxProbe - 1);
            state_d = StDispRd;
          end
        end else if (p_q == DistW'(1)) begin
          res_d      = 1'b0;
          res_pend_d = 1'b1;
          state_d    = StIdle;
        end else begin
          p_d     = p_q - DistW'(1);
          state_d = StDispRd;
        end
      end
      StFinWr: begin
        we         = 1'b1;
        waddr      = (home_q + cur_d_q) & mask;
        wdata      = put_slot(hole_q, cur_s_q, {fp_q, cur_d_q[DistW-1:0]});
        res_d      = 1'b1;
        res_pend_d = 1'b1;
        state_d    = StIdle;
      end
      StLookRd: begin
        rd_en   = 1'b1;
        state_d = StLookEv;
      end
      StLookEv: begin
        if (look_hit || p_q == DistW'(MaxProbe - 1)) begin
          res_d      = look_hit;
          res_pend_d = 1'b1;
          state_d    = StIdle;
        end else begin
          p_d     = p_q + DistW'(1);
          state_d = StLookRd;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (rd_en) rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i) begin
    hole_q  <= hole_d;
    cur_d_q <= cur_d_d;
    cur_s_q <= cur_s_d;
    d_q     <= d_d;
    p_q     <= p_d;
    res_q   <= res_d;
    if (accept) begin
      home_q <= s_axis_tdata[AddrW+1:2] & mask;
      fp_q   <= in_fp;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClr;
      clr_q       <= '0;
      lg_q        <= 4'd10;
      op_q        <= OpNone;
      res_pend_q  <= 1'b0;
      out_valid_q <= 1'b0;
      out_bit_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      if (cfg_we) lg_q <= pwdata[3:0];
      if (accept) op_q <= s_axis_tdata[1:0];
      // a clear result waits until the sweep is over
      res_pend_q <= (state_q == StClr) ? res_pend_q : res_pend_d;
      if (res_pend_q && state_q != StClr && (!out_valid_q || m_axis_tready)) begin
        out_valid_q <= 1'b1;
        out_bit_q   <= res_q;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

// ----- hw/rtl/ffh_checker.sv -----
// port-level checker for the hopscotch fingerprint filter, bound to the top level
// depends on assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ffh_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       pready
);
  `ASSERT_ALWAYS(a_pready_high, clk_i, rst_ni, pready)
  `ASSERT_ALWAYS(a_pad_zero, clk_i, rst_ni, !m_axis_tvalid || m_axis_tdata[7:1] == 7'd0)
  `ASSERT_NEXT(a_out_holds, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `ASSERT_NEXT(a_sweep_after_reset, clk_i, rst_ni, $rose(rst_ni), !s_axis_tready)
endmodule

bind fingerprint_filter_hopscotch ffh_checker u_ffh_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .pready        (pready)
);

// ----- bench/fingerprint_filter_hopscotch_tb.sv -----
// self-checking bench for the hopscotch fingerprint filter: directed table then random phases
// depends on ffh_pkg and fingerprint_filter_hopscotch
`timescale 1ns / 1ps
module fingerprint_filter_hopscotch_tb;
  import ffh_pkg::*;

  localparam int          QuietLimit     = 200000;
  localparam int          Unknown        = 2;
  localparam int          NoCfg          = -1;
  localparam logic [2:0]  AddrBucketLog2 = 3'd0;
  localparam int          PhaseItems     = 150;

  typedef struct {
    int         cfg;
    logic [1:0] op;
    logic [63:0] hash;
    int         want;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata = '0;   // opcode[1:0], hash_value[65:2], zero pad
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;        // success[0], zero pad
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  fingerprint_filter_hopscotch dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // shadow of the filter
  word_t      shadow_table [MaxBuckets];
  logic [3:0] shadow_log2;
  bit         success_q [$];
  logic [63:0] inserted_hashes [$];

  int  mismatches = 0;
  int  quiet_cycles = 0;
  bit  src_gaps = 1'b1;
  bit  sink_gaps = 1'b1;

  function automatic int unsigned buckets_in_use();
    logic [3:0] lg;
    lg = shadow_log2;
    if (lg > 4'(MaxLog2)) lg = 4'(MaxLog2);
    return 1 << lg;
  endfunction

  function automatic logic [15:0] shadow_slot(int unsigned b, int unsigned s);
    return shadow_table[b][s*SlotW +: SlotW];
  endfunction

  function automatic logic [11:0] hash_fp(logic [63:0] h);
    return (h[43:32] == '0) ? 12'd1 : h[43:32];
  endfunction

  function automatic bit filter_insert(logic [63:0] h);
    int unsigned n, mask, home, d, s, cur_d, cur_s, p, cb, cs;
    logic [15:0] t;
    bit moved;
    n = buckets_in_use();
    mask = n - 1;
    home = h[31:0] & mask;
    for (d = 0; d < n; d++) begin
      for (s = 0; s < Slots; s++) begin
        if (shadow_slot((home + d) & mask, s) != '0) continue;
        cur_d = d;
        cur_s = s;
        while (cur_d >= MaxProbe) begin
          moved = 1'b0;
          // farthest candidate bucket first
          for (p = MaxProbe - 1; p > 0 && !moved; p--) begin
            cb = (home + cur_d - p) & mask;
            for (cs = 0; cs < Slots && !moved; cs++) begin
              t = shadow_slot(cb, cs);
              if (int'(t[3:0]) + p < MaxProbe) begin
                shadow_table[(home + cur_d) & mask][cur_s*SlotW +: SlotW] =
                  {t[15:4], 4'(t[3:0] + p)};
                cur_d = cur_d - p;
                cur_s = cs;
                moved = 1'b1;
              end
            end
          end
          if (!moved) return 1'b0;
        end
        shadow_table[(home + cur_d) & mask][cur_s*SlotW +: SlotW] = {hash_fp(h), 4'(cur_d)};
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic bit filter_lookup(logic [63:0] h);
    int unsigned n, mask, home, p, s;
    n = buckets_in_use();
    mask = n - 1;
    home = h[31:0] & mask;
    for (p = 0; p < MaxProbe; p++)
      for (s = 0; s < Slots; s++)
        if (shadow_slot((home + p) & mask, s) == {hash_fp(h), 4'(p)}) return 1'b1;
    return 1'b0;
  endfunction

  function automatic bit filter_step(logic [1:0] op, logic [63:0] h);
    case (op)
      OpInsert: return filter_insert(h);
      OpLookup: return filter_lookup(h);
      OpClear: begin
        foreach (shadow_table[i]) shadow_table[i] = '0;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic send_item(logic [1:0] op, logic [63:0] h, int want);
    bit predicted;
    if (src_gaps && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, h, op};
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = filter_step(op, h);
    success_q.push_back(want == Unknown ? predicted : bit'(want));
    if (op == OpInsert) inserted_hashes.push_back(h);
  endtask

  task automatic write_bucket_log2(logic [3:0] v);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (success_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= AddrBucketLog2;
    pwdata  <= 32'(v);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    shadow_log2 = v;
  endtask

  // random hash, often clustered on a few homes so probing and displacement get deep
  function automatic logic [63:0] random_hash(int unsigned base);
    logic [63:0] h;
    h = {$urandom, $urandom};
    if ($urandom_range(0, 3) != 0) h[31:0] = base + $urandom_range(0, 5);
    if ($urandom_range(0, 7) == 0) h[43:32] = '0;
    return h;
  endfunction

  // result side
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (success_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transaction success=%0b",
                                       m_axis_tdata[0]);
      end else begin
        if (m_axis_tdata[0] !== success_q[0]) begin
          mismatches++;
          if (mismatches <= 10) $display("success mismatch: expected %0b actual %0b",
                                         success_q[0], m_axis_tdata[0]);
        end
        void'(success_q.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QuietLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    forever begin
      if (sink_gaps && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
    end
  end

  row_t directed [22] = '{
    '{NoCfg, OpLookup, 64'h0,                   0},
    '{NoCfg, OpInsert, 64'h0,                   1},
    '{NoCfg, OpLookup, 64'h0,                   1},
    // zero fingerprint is stored as one
    '{NoCfg, OpLookup, 64'h0000_0001_0000_0000, 1},
    '{NoCfg, OpInsert, 64'hFFFF_FFFF_FFFF_FFFF, 1},
    '{NoCfg, OpLookup, 64'hFFFF_FFFF_FFFF_FFFF, 1},
    '{NoCfg, OpNone,   64'hFFFF_FFFF_FFFF_FFFF, 0},
    '{NoCfg, OpLookup, 64'hFFFF_FFFF_FFFF_FFFF, 1},
    '{NoCfg, OpClear,  64'hA5A5_5A5A_F0F0_0F0F, 1},
    '{NoCfg, OpLookup, 64'hFFFF_FFFF_FFFF_FFFF, 0},
    // single bucket: four slots then full
    '{0,     OpInsert, 64'h0000_0000_0000_0005, 1},
    '{NoCfg, OpInsert, 64'h0000_0ABC_0000_0007, 1},
    '{NoCfg, OpInsert, 64'h0000_0FFF_0000_0009, 1},
    '{NoCfg, OpInsert, 64'h0000_0123_0000_000B, 1},
    '{NoCfg, OpInsert, 64'h0000_0456_0000_000D, 0},
    '{NoCfg, OpLookup, 64'h0000_0ABC_0000_0000, 1},
    '{NoCfg, OpLookup, 64'h0000_0456_0000_000D, 0},
    // oversized count falls back to the full table
    '{15,    OpInsert, 64'h0000_0777_0000_03FF, 1},
    '{NoCfg, OpLookup, 64'h0000_0777_0000_03FF, 1},
    '{NoCfg, OpLookup, 64'h0000_0777_0000_07FF, 1},
    '{NoCfg, OpNone,   64'h0,                   0},
    '{NoCfg, OpClear,  64'h0,                   1}
  };

  int unsigned phase_log2 [11] = '{5, 1, 4, 10, 0, 3, 5, 2, 10, 6, 4};

  initial begin
    int unsigned n, base, r, pick;
    logic [1:0]  op;
    logic [63:0] h;
    foreach (shadow_table[i]) shadow_table[i] = '0;
    shadow_log2 = 4'd10;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed[i]) begin
      if (directed[i].cfg != NoCfg) write_bucket_log2(4'(directed[i].cfg));
      send_item(directed[i].op, directed[i].hash, directed[i].want);
    end

    foreach (phase_log2[k]) begin
      write_bucket_log2(4'(phase_log2[k]));
      if (k == $size(phase_log2) - 1) begin
        src_gaps  = 1'b0;
        sink_gaps = 1'b0;
      end
      n = buckets_in_use();
      base = $urandom_range(0, n - 1);
      for (int j = 0; j < PhaseItems; j++) begin
        r = $urandom_range(0, 99);
        if (r < 55)      op = OpInsert;
        else if (r < 96) op = OpLookup;
        else if (r < 98) op = OpClear;
        else             op = OpNone;
        h = random_hash(base);
        if (op == OpLookup && inserted_hashes.size() != 0 && $urandom_range(0, 1)) begin
          pick = $urandom_range(0, inserted_hashes.size() - 1);
          h = inserted_hashes[pick];
        end
        send_item(op, h, Unknown);
      end
      inserted_hashes.delete();
    end

    s_axis_tvalid <= 1'b0;
    while (success_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
